// ===== hdl/lgts_pkg.sv =====
`default_nettype none
package lgts_pkg;

    // default sizes
    localparam int TOPICS_DEF     = 32;
    localparam int VOCAB_DEF      = 4096;
    localparam int DOCS_DEF       = 1024;
    localparam int LANGS_DEF      = 2;
    localparam int COUNT_BITS_DEF = 24;

    // fixed field widths
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 2;
    localparam int LANG_W  = 1;
    localparam int DOC_W   = 10;
    localparam int WORD_W  = 12;
    localparam int TOPIC_W = 5;
    localparam int UNI_W   = 16;
    localparam int FRAC_W  = 16;
    localparam int WGT_W   = 40;

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_ALPHA      = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_BETA       = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_BETA_VOCAB = 2'd2;

    // register reset values
    localparam logic [CFG_W-1:0] ALPHA_RST      = 32'd4096;
    localparam logic [CFG_W-1:0] BETA_RST       = 32'd655;
    localparam logic [CFG_W-1:0] BETA_VOCAB_RST = 32'd2684355;

    localparam logic [WGT_W-1:0] WGT_MAX = {WGT_W{1'b1}};

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_FAC,
        S_MUL,
        S_DIV,
        S_WR,
        S_UT,
        S_SRD,
        S_SCMP,
        S_URD,
        S_UWR,
        S_OUT
    } state_t;

endpackage
`default_nettype wire

// ===== hdl/lgts_if.sv =====
`default_nettype none
// token channel
interface lgts_tok_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [lgts_pkg::LANG_W-1:0]  language;
    logic [lgts_pkg::DOC_W-1:0]   document;
    logic [lgts_pkg::WORD_W-1:0]  word;
    logic [lgts_pkg::TOPIC_W-1:0] old_topic;
    logic [lgts_pkg::UNI_W-1:0]   uniform;
    modport source (output valid, mode, language, document, word, old_topic, uniform,
                    input ready);
    modport sink   (input valid, mode, language, document, word, old_topic, uniform,
                    output ready);
endinterface

// result channel
interface lgts_res_if;
    logic                        valid;
    logic                        ready;
    logic [lgts_pkg::TOPIC_W-1:0] new_topic;
    logic                        failed;
    modport source (output valid, new_topic, failed, input ready);
    modport sink   (input valid, new_topic, failed, output ready);
endinterface
`default_nettype wire

// ===== hdl/lda_gibbs_token_sampler.sv =====
// Collapsed Gibbs token sampler, one token item per accepted input.
// Channels: tok (sink) carries mode, language, document, word, old_topic and
// uniform; res (source) carries new_topic and failed. An item moves when
// valid and ready are both high. cfg_we/cfg_index/cfg_data write alpha,
// beta and beta_vocab; write only while the block is idle.
// After reset the three count tables are swept to zero, one entry a cycle,
// over max(DOCS*TOPICS, LANGS*VOCAB*TOPICS, LANGS*TOPICS) addresses (262144 at
// defaults); tok.ready stays low meanwhile.
// Init mode steps through accept, read, write and result. Resample mode works
// one topic at a time through a shift-add multiplier and a restoring divider,
// one bit a cycle, on factors of F = COUNT_BITS+17 bits (41 by default); both
// are skipped when the denominator is zero. The total is then scaled by the
// uniform, a cumulative search compares topic by topic, and when the topic
// changes the old topic's counts are decremented and the new topic's incremented.
// The result sits in an output register; while the receiver stalls the
// block holds it and takes no new item.
`default_nettype none
module lda_gibbs_token_sampler #(
    parameter int TOPICS     = lgts_pkg::TOPICS_DEF,
    parameter int VOCAB      = lgts_pkg::VOCAB_DEF,
    parameter int DOCS       = lgts_pkg::DOCS_DEF,
    parameter int LANGS      = lgts_pkg::LANGS_DEF,
    parameter int COUNT_BITS = lgts_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    lgts_tok_if.sink                           tok,
    lgts_res_if.source                         res,
    input  wire logic                          cfg_we,
    input  wire logic [lgts_pkg::CIDX_W-1:0]   cfg_index,
    input  wire logic [lgts_pkg::CFG_W-1:0]    cfg_data
);

    localparam int TW     = $clog2(TOPICS);
    localparam int XW     = 11;
    localparam int DT_D   = DOCS * TOPICS;
    localparam int WT_D   = LANGS * VOCAB * TOPICS;
    localparam int LT_D   = LANGS * TOPICS;
    localparam int DAW    = $clog2(DT_D);
    localparam int WAW    = $clog2(WT_D);
    localparam int LAW    = $clog2(LT_D);
    localparam int CLR_D  = (DT_D > WT_D) ? ((DT_D > LT_D) ? DT_D : LT_D)
                                          : ((WT_D > LT_D) ? WT_D : LT_D);
    localparam int CLW    = $clog2(CLR_D);
    localparam int FW     = COUNT_BITS + 17;
    localparam int PW     = 2 * FW;
    localparam int BCW    = $clog2(PW + 1);
    localparam int TOT_W  = lgts_pkg::WGT_W + TW;
    localparam int UTW    = TOT_W + lgts_pkg::UNI_W;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    lgts_pkg::state_t state_reg, state_next;

    // configuration registers
    logic [lgts_pkg::CFG_W-1:0] alpha_reg, beta_reg, bv_reg;

    // captured item
    logic                         mode_reg;
    logic [lgts_pkg::LANG_W-1:0]  lang_reg;
    logic [lgts_pkg::DOC_W-1:0]   doc_reg;
    logic [lgts_pkg::WORD_W-1:0]  word_reg;
    logic [lgts_pkg::TOPIC_W-1:0] old_reg;
    logic [lgts_pkg::UNI_W-1:0]   uni_reg;

    // datapath
    logic [CLW-1:0]                clr_cnt_reg;
    logic [TW-1:0]                 k_reg;
    logic [FW-1:0]                 c_reg, b_reg;
    logic [PW-1:0]                 ash_reg, prod_reg;
    logic [FW-1:0]                 rem_reg;
    logic [lgts_pkg::WGT_W-1:0]    q_reg;
    logic                          sat_reg, zero_reg;
    logic [BCW-1:0]                bit_reg;
    logic [TOT_W-1:0]              total_reg, cum_reg;
    logic [UTW-1:0]                ut_reg;
    logic [TW-1:0]                 pick_reg;
    logic                          failed_reg;
    logic [lgts_pkg::TOPIC_W-1:0]  res_topic_reg;
    logic                          dec_pend_reg, inc_pend_reg;

    // memories
    logic [COUNT_BITS-1:0] dt_mem [DT_D];
    logic [COUNT_BITS-1:0] wt_mem [WT_D];
    logic [COUNT_BITS-1:0] lt_mem [LT_D];
    logic [lgts_pkg::WGT_W-1:0] wg_mem [TOPICS];
    logic [COUNT_BITS-1:0] dt_rd, wt_rd, lt_rd;
    logic [lgts_pkg::WGT_W-1:0] wg_rd;

    logic                  cnt_we, wg_we;
    logic [DAW-1:0]        dt_a;
    logic [WAW-1:0]        wt_a;
    logic [LAW-1:0]        lt_a;
    logic [COUNT_BITS-1:0] dt_wd, wt_wd, lt_wd;
    logic                  dt_clr_ok, wt_clr_ok, lt_clr_ok;
    logic [lgts_pkg::WGT_W-1:0] wg_wd;

    // helpers
    logic              in_range, old_ok, is_old, k_last;
    logic [XW-1:0]     old_x;
    logic [TW-1:0]     addr_topic;
    logic [39:0]       d_lin, w_lin, l_lin;
    logic [FW-1:0]     dec_v, fa, fb, fc, va, vb, vc;
    logic [FW:0]       rem2;
    logic              ge;
    logic [TOT_W-1:0]  cum_n;
    logic              hit;

    assign old_x       = XW'(old_reg);
    assign old_ok      = old_x < XW'(TOPICS);
    assign is_old      = XW'(k_reg) == old_x;
    assign k_last      = k_reg == TW'(TOPICS - 1);
    assign in_range    = (32'(tok.language) < 32'(LANGS)) && (32'(tok.document) < 32'(DOCS))
                         && (32'(tok.word) < 32'(VOCAB));

    // linear table addresses
    assign addr_topic = (state_reg == lgts_pkg::S_RD) ? k_reg
                      : (dec_pend_reg ? TW'(old_reg) : pick_reg);
    assign d_lin = 40'(doc_reg) * 40'(TOPICS) + 40'(addr_topic);
    assign w_lin = (40'(lang_reg) * 40'(VOCAB) + 40'(word_reg)) * 40'(TOPICS)
                   + 40'(addr_topic);
    assign l_lin = 40'(lang_reg) * 40'(TOPICS) + 40'(addr_topic);

    // factors: (count << 16) + prior - dec, floored at zero
    assign dec_v = is_old ? FW'(1 << lgts_pkg::FRAC_W) : '0;
    assign va = {dt_rd, 16'b0} + FW'(alpha_reg);
    assign vb = {wt_rd, 16'b0} + FW'(beta_reg);
    assign vc = {lt_rd, 16'b0} + FW'(bv_reg);
    assign fa = (va >= dec_v) ? va - dec_v : '0;
    assign fb = (vb >= dec_v) ? vb - dec_v : '0;
    assign fc = (vc >= dec_v) ? vc - dec_v : '0;

    // divider step
    assign rem2 = {rem_reg, prod_reg[PW-1]};
    assign ge   = rem2 >= {1'b0, c_reg};

    // search step
    assign cum_n = cum_reg + TOT_W'(wg_rd);
    assign hit   = {cum_n, 16'b0} > ut_reg;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lgts_pkg::S_CLEAR;
            clr_cnt_reg <= '0;
            alpha_reg   <= lgts_pkg::ALPHA_RST;
            beta_reg    <= lgts_pkg::BETA_RST;
            bv_reg      <= lgts_pkg::BETA_VOCAB_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == lgts_pkg::S_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cfg_we)
            begin
                case (cfg_index)
                    lgts_pkg::CFG_ALPHA:      alpha_reg <= cfg_data;
                    lgts_pkg::CFG_BETA:       beta_reg  <= cfg_data;
                    lgts_pkg::CFG_BETA_VOCAB: bv_reg    <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lgts_pkg::S_CLEAR:
                if (clr_cnt_reg == CLW'(CLR_D - 1))
                    state_next = lgts_pkg::S_IDLE;
            lgts_pkg::S_IDLE:
                if (tok.valid)
                begin
                    if (!in_range)
                        state_next = lgts_pkg::S_OUT;
                    else if (!tok.mode)
                        state_next = (XW'(tok.old_topic) < XW'(TOPICS)) ? lgts_pkg::S_URD
                                                                       : lgts_pkg::S_OUT;
                    else
                        state_next = lgts_pkg::S_RD;
                end
            lgts_pkg::S_RD:   state_next = lgts_pkg::S_FAC;
            lgts_pkg::S_FAC:  state_next = (fc == '0) ? lgts_pkg::S_WR : lgts_pkg::S_MUL;
            lgts_pkg::S_MUL:
                if (bit_reg == BCW'(FW - 1))
                    state_next = lgts_pkg::S_DIV;
            lgts_pkg::S_DIV:
                if (bit_reg == '0)
                    state_next = lgts_pkg::S_WR;
            lgts_pkg::S_WR:   state_next = k_last ? lgts_pkg::S_UT : lgts_pkg::S_RD;
            lgts_pkg::S_UT:
                // zero total: the token goes to topic zero
                if (total_reg == '0)
                    state_next = (old_x != '0) ? lgts_pkg::S_URD : lgts_pkg::S_OUT;
                else
                    state_next = lgts_pkg::S_SRD;
            lgts_pkg::S_SRD:  state_next = lgts_pkg::S_SCMP;
            lgts_pkg::S_SCMP:
                if (hit || k_last)
                    state_next = ((hit ? XW'(k_reg) : '0) != old_x) ? lgts_pkg::S_URD
                                                                   : lgts_pkg::S_OUT;
                else
                    state_next = lgts_pkg::S_SRD;
            lgts_pkg::S_URD:  state_next = lgts_pkg::S_UWR;
            lgts_pkg::S_UWR:
                state_next = (dec_pend_reg && inc_pend_reg) ? lgts_pkg::S_URD
                                                            : lgts_pkg::S_OUT;
            lgts_pkg::S_OUT:
                if (res.ready)
                    state_next = lgts_pkg::S_IDLE;
            default:          state_next = lgts_pkg::S_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb
    begin
        tok.ready     = state_reg == lgts_pkg::S_IDLE;
        res.valid     = state_reg == lgts_pkg::S_OUT;
        res.new_topic = res_topic_reg;
        res.failed    = failed_reg;
        cnt_we        = 1'b0;
        wg_we         = state_reg == lgts_pkg::S_WR;
        wg_wd         = zero_reg ? '0 : (sat_reg ? lgts_pkg::WGT_MAX : q_reg);
        dt_a          = d_lin[DAW-1:0];
        wt_a          = w_lin[WAW-1:0];
        lt_a          = l_lin[LAW-1:0];
        dt_clr_ok     = 1'b1;
        wt_clr_ok     = 1'b1;
        lt_clr_ok     = 1'b1;
        if (dec_pend_reg)
        begin
            dt_wd = (dt_rd == '0) ? dt_rd : dt_rd - 1'b1;
            wt_wd = (wt_rd == '0) ? wt_rd : wt_rd - 1'b1;
            lt_wd = (lt_rd == '0) ? lt_rd : lt_rd - 1'b1;
        end
        else
        begin
            dt_wd = (dt_rd == CMAX) ? dt_rd : dt_rd + 1'b1;
            wt_wd = (wt_rd == CMAX) ? wt_rd : wt_rd + 1'b1;
            lt_wd = (lt_rd == CMAX) ? lt_rd : lt_rd + 1'b1;
        end
        case (state_reg)
            lgts_pkg::S_CLEAR:
            begin
                cnt_we    = 1'b1;
                dt_a      = clr_cnt_reg[DAW-1:0];
                wt_a      = clr_cnt_reg[WAW-1:0];
                lt_a      = clr_cnt_reg[LAW-1:0];
                dt_wd     = '0;
                wt_wd     = '0;
                lt_wd     = '0;
                dt_clr_ok = 32'(clr_cnt_reg) < 32'(DT_D);
                wt_clr_ok = 32'(clr_cnt_reg) < 32'(WT_D);
                lt_clr_ok = 32'(clr_cnt_reg) < 32'(LT_D);
            end
            lgts_pkg::S_UWR: cnt_we = 1'b1;
            default: ;
        endcase
    end

    // count tables
    always_ff @(posedge clk)
    begin
        if (cnt_we && dt_clr_ok)
            dt_mem[dt_a] <= dt_wd;
        dt_rd <= dt_mem[dt_a];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we && wt_clr_ok)
            wt_mem[wt_a] <= wt_wd;
        wt_rd <= wt_mem[wt_a];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we && lt_clr_ok)
            lt_mem[lt_a] <= lt_wd;
        lt_rd <= lt_mem[lt_a];
    end

    // topic weights
    always_ff @(posedge clk)
    begin
        if (wg_we)
            wg_mem[k_reg] <= wg_wd;
        wg_rd <= wg_mem[k_reg];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            lgts_pkg::S_IDLE:
            begin
                mode_reg      <= tok.mode;
                lang_reg      <= tok.language;
                doc_reg       <= tok.document;
                word_reg      <= tok.word;
                old_reg       <= tok.old_topic;
                uni_reg       <= tok.uniform;
                res_topic_reg <= tok.old_topic;
                failed_reg    <= 1'b0;
                pick_reg      <= TW'(tok.old_topic);
                dec_pend_reg  <= 1'b0;
                inc_pend_reg  <= 1'b1;
                k_reg         <= '0;
                total_reg     <= '0;
            end
            lgts_pkg::S_FAC:
            begin
                ash_reg  <= PW'(fa);
                b_reg    <= fb;
                c_reg    <= fc;
                prod_reg <= '0;
                rem_reg  <= '0;
                q_reg    <= '0;
                sat_reg  <= 1'b0;
                zero_reg <= fc == '0;
                bit_reg  <= '0;
            end
            lgts_pkg::S_MUL:
            begin
                // shift-add, one multiplier bit a cycle
                prod_reg <= prod_reg + (b_reg[0] ? ash_reg : '0);
                ash_reg  <= ash_reg << 1;
                b_reg    <= b_reg >> 1;
                bit_reg  <= (bit_reg == BCW'(FW - 1)) ? BCW'(PW - 1) : bit_reg + 1'b1;
            end
            lgts_pkg::S_DIV:
            begin
                // restoring division, quotient bit index in bit_reg
                rem_reg  <= ge ? FW'(rem2 - {1'b0, c_reg}) : rem_reg << 1 | FW'(rem2[0]);
                prod_reg <= prod_reg << 1;
                q_reg    <= {q_reg[lgts_pkg::WGT_W-2:0], ge};
                if (ge && bit_reg >= BCW'(lgts_pkg::WGT_W))
                    sat_reg <= 1'b1;
                bit_reg  <= bit_reg - 1'b1;
            end
            lgts_pkg::S_WR:
            begin
                total_reg <= total_reg + TOT_W'(wg_wd);
                k_reg     <= k_last ? '0 : k_reg + 1'b1;
            end
            lgts_pkg::S_UT:
            begin
                ut_reg  <= UTW'(uni_reg) * UTW'(total_reg);
                cum_reg <= '0;
                k_reg   <= '0;
                if (total_reg == '0)
                begin
                    pick_reg      <= '0;
                    failed_reg    <= 1'b1;
                    res_topic_reg <= '0;
                    dec_pend_reg  <= old_ok && (old_x != '0);
                end
            end
            lgts_pkg::S_SCMP:
            begin
                cum_reg <= cum_n;
                if (hit || k_last)
                begin
                    pick_reg      <= hit ? k_reg : '0;
                    failed_reg    <= !hit;
                    res_topic_reg <= hit ? lgts_pkg::TOPIC_W'(XW'(k_reg)) : '0;
                    dec_pend_reg  <= old_ok && ((hit ? XW'(k_reg) : '0) != old_x);
                end
                else
                    k_reg <= k_reg + 1'b1;
            end
            lgts_pkg::S_UWR:
            begin
                if (dec_pend_reg)
                    dec_pend_reg <= 1'b0;
                else
                    inc_pend_reg <= 1'b0;
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    // no new item while a result is on offer
    assert property (@(posedge clk) disable iff (!rst_n) res.valid |-> !tok.ready)
        else $error("item accepted while result pending");
    // a failed draw answers topic zero
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.failed |-> res.new_topic == '0)
        else $error("failed result with non-zero topic");
    // the clearing sweep blocks input
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lgts_pkg::S_CLEAR |-> !tok.ready && !res.valid)
        else $error("handshake during clearing sweep");
    // init mode never runs the weight pass
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lgts_pkg::S_RD |-> mode_reg)
        else $error("weight pass in init mode");
`endif

endmodule
`default_nettype wire
